[design/walsh_hadamard_xor_transform_mod_p_macros.svh]
// Assertion macros used by the checker file of the xor transform block.
// Depends on nothing; included by bare file name.
`ifndef WALSH_HADAMARD_XOR_TRANSFORM_MOD_P_MACROS_SVH
`define WALSH_HADAMARD_XOR_TRANSFORM_MOD_P_MACROS_SVH

// Same-cycle implication.
`define WHT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/wht_pkg.sv]
// Shared types, constants and modular helpers for the xor transform block.
// No dependencies.
package wht_pkg;

  localparam int VALUE_W        = 30;
  localparam int LOG_W          = 4;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 4;
  localparam int MAX_POINTS_DEF = 1024;

  localparam logic [VALUE_W-1:0] MODP           = 30'd1000000007;
  localparam logic [LOG_W-1:0]   LOG_SIZE_RESET = 4'd10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOG_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE  = 1'd1;

  // Write data select codes
  localparam logic [1:0] WSEL_LOAD = 2'd0;
  localparam logic [1:0] WSEL_SUM  = 2'd1;
  localparam logic [1:0] WSEL_DIFF = 2'd2;

  typedef struct packed {
    logic       we;       // write memory at waddr
    logic [1:0] wsel;     // write data source
    logic       rd_en;    // read both ports into the read registers
    logic       calc_en;  // register sum and difference
    logic       halve;    // multiply butterfly outputs by 1/2 mod p
    logic       out_load; // move port A read data to the result register
  } dp_cmd_t;

  // Single conditional subtract, valid for x < 2p.
  function automatic logic [VALUE_W-1:0] reduce_once(input logic [VALUE_W-1:0] x);
    if (x >= MODP) return x - MODP;
    return x;
  endfunction

  function automatic logic [VALUE_W-1:0] add_mod(input logic [VALUE_W-1:0] a,
                                                 input logic [VALUE_W-1:0] b);
    logic [VALUE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODP}) s = s - {1'b0, MODP};
    return s[VALUE_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] sub_mod(input logic [VALUE_W-1:0] a,
                                                 input logic [VALUE_W-1:0] b);
    logic [VALUE_W:0] t;
    t = {1'b0, a} + {1'b0, MODP} - {1'b0, b};
    if (a >= b) return a - b;
    return t[VALUE_W-1:0];
  endfunction

  // x / 2 mod p: odd values get p added first (p is odd).
  function automatic logic [VALUE_W-1:0] half_mod(input logic [VALUE_W-1:0] x);
    logic [VALUE_W:0] t;
    t = {1'b0, x} + (x[0] ? {1'b0, MODP} : {(VALUE_W+1){1'b0}});
    return t[VALUE_W:1];
  endfunction

endpackage

[design/wht_datapath.sv]
// Datapath: element memory, read registers, butterfly add/sub, result register.
// Depends on wht_pkg.
module wht_datapath #(
  parameter int MAX_POINTS = wht_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  wht_pkg::dp_cmd_t              cmd,
  input  logic [$clog2(MAX_POINTS)-1:0] waddr,
  input  logic [$clog2(MAX_POINTS)-1:0] raddr_a,
  input  logic [$clog2(MAX_POINTS)-1:0] raddr_b,
  input  logic [wht_pkg::VALUE_W-1:0]   load_value,
  output logic [wht_pkg::VALUE_W-1:0]   result_value
);
  import wht_pkg::*;

  logic [VALUE_W-1:0] mem [MAX_POINTS];
  logic [VALUE_W-1:0] rd_a;
  logic [VALUE_W-1:0] rd_b;
  logic [VALUE_W-1:0] sum;
  logic [VALUE_W-1:0] diff;
  logic [VALUE_W-1:0] wdata;

  always_comb begin
    case (cmd.wsel)
      WSEL_LOAD: wdata = reduce_once(load_value);
      WSEL_SUM:  wdata = cmd.halve ? half_mod(sum) : sum;
      WSEL_DIFF: wdata = cmd.halve ? half_mod(diff) : diff;
      default:   wdata = reduce_once(load_value);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_a <= mem[raddr_a];
      rd_b <= mem[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_en) begin
      sum  <= add_mod(rd_a, rd_b);
      diff <= sub_mod(rd_a, rd_b);
    end
    if (cmd.out_load) begin
      result_value <= rd_a;
    end
  end

endmodule

[design/wht_ctrl.sv]
// Controller: config registers, load/read counters, butterfly sequencer, result valid.
// Depends on wht_pkg.
module wht_ctrl #(
  parameter int MAX_POINTS = wht_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic                            mode,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wht_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wht_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            last,
  output wht_pkg::dp_cmd_t                cmd,
  output logic [$clog2(MAX_POINTS)-1:0]   waddr,
  output logic [$clog2(MAX_POINTS)-1:0]   raddr_a,
  output logic [$clog2(MAX_POINTS)-1:0]   raddr_b
);
  import wht_pkg::*;

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int CW     = AW + 1;
  localparam int LG_MAX = $clog2(MAX_POINTS + 1) - 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RD_WAIT = 3'd1;
  localparam logic [2:0] S_BF_RD   = 3'd2;
  localparam logic [2:0] S_BF_CALC = 3'd3;
  localparam logic [2:0] S_BF_WA   = 3'd4;
  localparam logic [2:0] S_BF_WB   = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [LOG_W-1:0] log_size;
  logic             inverse;
  logic [AW-1:0]    load_count;
  logic [AW-1:0]    read_count;
  logic             transformed;
  logic [AW-1:0]    half_bit;
  logic [AW-1:0]    base;
  logic [AW-1:0]    off;
  logic             last_pend;

  logic [LOG_W-1:0] lg_eff;
  logic [CW-1:0]    n_pts;
  logic             load_acc;
  logic             read_acc;
  logic [AW-1:0]    load_addr;
  logic             load_wrap;
  logic             rd_last;
  logic [AW-1:0]    bf_lo;
  logic [AW-1:0]    bf_hi;
  logic             off_last;
  logic             blk_last;
  logic             lvl_last;
  logic             out_free;
  logic             cfg_we;

  // Effective size: log_size clamped to 1..log2 of the largest power of two that fits.
  always_comb begin
    if (log_size == '0) begin
      lg_eff = LOG_W'(1);
    end else if (int'(log_size) > LG_MAX) begin
      lg_eff = LOG_W'(LG_MAX);
    end else begin
      lg_eff = log_size;
    end
    n_pts = CW'(1) << lg_eff;
  end

  assign cfg_ready  = 1'b1;
  assign cfg_we     = cfg_valid & cfg_ready;
  assign item_stall = (state != S_IDLE);
  assign load_acc   = item_valid & ~item_stall & ~mode;
  assign read_acc   = item_valid & ~item_stall & mode & transformed;
  assign load_addr  = transformed ? '0 : load_count;
  assign load_wrap  = (CW'(load_addr) + CW'(1)) == n_pts;
  assign rd_last    = (CW'(read_count) + CW'(1)) == n_pts;
  assign out_free   = ~result_valid | ~result_stall;

  // Butterfly pair: low index has the level bit clear, partner has it set.
  assign bf_lo    = base | off;
  assign bf_hi    = bf_lo | half_bit;
  assign off_last = (off == (half_bit - AW'(1)));
  assign blk_last = (CW'(base) + (CW'(half_bit) << 1)) == n_pts;
  assign lvl_last = (CW'(half_bit) << 1) == n_pts;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (load_acc && load_wrap) begin
          state_next = S_BF_RD;
        end else if (read_acc) begin
          state_next = S_RD_WAIT;
        end
      end
      S_RD_WAIT: if (out_free) state_next = S_IDLE;
      S_BF_RD:   state_next = S_BF_CALC;
      S_BF_CALC: state_next = S_BF_WA;
      S_BF_WA:   state_next = S_BF_WB;
      S_BF_WB: begin
        if (off_last && blk_last && lvl_last) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_BF_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.halve    = inverse;
    cmd.wsel     = WSEL_LOAD;
    waddr        = load_addr;
    raddr_a      = read_count;
    raddr_b      = bf_hi;
    case (state)
      S_IDLE: begin
        cmd.we    = load_acc;
        cmd.rd_en = read_acc;
      end
      S_RD_WAIT: cmd.out_load = out_free;
      S_BF_RD: begin
        cmd.rd_en = 1'b1;
        raddr_a   = bf_lo;
      end
      S_BF_CALC: cmd.calc_en = 1'b1;
      S_BF_WA: begin
        cmd.we   = 1'b1;
        cmd.wsel = WSEL_SUM;
        waddr    = bf_lo;
      end
      S_BF_WB: begin
        cmd.we   = 1'b1;
        cmd.wsel = WSEL_DIFF;
        waddr    = bf_hi;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      log_size     <= LOG_SIZE_RESET;
      inverse      <= 1'b0;
      load_count   <= '0;
      read_count   <= '0;
      transformed  <= 1'b0;
      result_valid <= 1'b0;
      half_bit     <= '0;
      base         <= '0;
      off          <= '0;
    end else begin
      state <= state_next;

      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (load_acc) begin
            if (transformed) begin
              transformed <= 1'b0;
              read_count  <= '0;
            end
            if (load_wrap) begin
              load_count <= '0;
              half_bit   <= AW'(1);
              base       <= '0;
              off        <= '0;
            end else begin
              load_count <= load_addr + AW'(1);
            end
          end else if (read_acc) begin
            read_count <= rd_last ? '0 : read_count + AW'(1);
          end
        end
        S_BF_WB: begin
          if (off_last) begin
            off <= '0;
            if (blk_last) begin
              base <= '0;
              if (lvl_last) begin
                transformed <= 1'b1;
                load_count  <= '0;
                read_count  <= '0;
              end else begin
                half_bit <= half_bit << 1;
              end
            end else begin
              base <= base + (half_bit << 1);
            end
          end else begin
            off <= off + AW'(1);
          end
        end
        default: ;
      endcase

      if (cfg_we && cfg_index == REG_INVERSE) begin
        inverse <= cfg_data[0];
      end
      if (cfg_we && cfg_index == REG_LOG_SIZE) begin
        log_size    <= cfg_data;
        load_count  <= '0;
        read_count  <= '0;
        transformed <= 1'b0;
      end
    end
  end

  // Payload side of the result: no reset needed
  always_ff @(posedge clk) begin
    if (read_acc) begin
      last_pend <= rd_last;
    end
    if (cmd.out_load) begin
      last <= last_pend;
    end
  end

endmodule

[design/walsh_hadamard_xor_transform_mod_p.sv]
// Top level of the xor (Walsh-Hadamard) transform modulo 1000000007.
// Depends on wht_pkg, wht_ctrl and wht_datapath.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  item     | item_valid/item_stall  | mode, value
//  result   | result_valid/...stall  | result_value, last
//  cfg      | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// The load that fills N = 2^log_size points starts the transform: each butterfly
// does a pair read, a sum/difference, then two writes through the single memory
// write port, with item_stall high throughout. A read transfer passes through the
// registered memory read and then the result register.
// Reset (rst, synchronous) clears control state only; element memory contents
// are undefined until loaded, so there is no clearing pass.
// A result held under result_stall does not block load transfers; a read waits
// for the result register to free up.
module walsh_hadamard_xor_transform_mod_p #(
  parameter int MAX_POINTS = wht_pkg::MAX_POINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // item channel
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic                           mode,
  input  logic [wht_pkg::VALUE_W-1:0]    value,
  // result channel
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [wht_pkg::VALUE_W-1:0]    result_value,
  output logic                           last,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wht_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wht_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wht_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  dp_cmd_t       cmd;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;

  // Sequencer: counters, config, butterfly order, result handshake
  wht_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .mode         (mode),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .last         (last),
    .cmd          (cmd),
    .waddr        (waddr),
    .raddr_a      (raddr_a),
    .raddr_b      (raddr_b)
  );

  // Element memory and modular butterfly arithmetic
  wht_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .waddr        (waddr),
    .raddr_a      (raddr_a),
    .raddr_b      (raddr_b),
    .load_value   (value),
    .result_value (result_value)
  );

endmodule

[design/wht_checker.sv]
// Port-level checker for the xor transform block, bound to the top level.
// Depends on wht_pkg and walsh_hadamard_xor_transform_mod_p_macros.svh.
`include "walsh_hadamard_xor_transform_mod_p_macros.svh"

module wht_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_stall,
  input logic                        mode,
  input logic                        result_valid,
  input logic                        result_stall,
  input logic [wht_pkg::VALUE_W-1:0] result_value,
  input logic                        last
);
  import wht_pkg::*;

  // stalled result holds
  `WHT_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall,
    result_valid && $stable(result_value) && $stable(last), "result changed under stall")

  // a fresh result follows an accepted read transfer
  `WHT_ASSERT_IMPLY(a_result_src, clk, rst, $rose(result_valid),
    $past(item_valid && !item_stall && mode, 2), "result without a read transfer")

  // final element is never followed directly by another final element
  `WHT_ASSERT_NEXT(a_last_once, clk, rst, result_valid && !result_stall && last,
    !(result_valid && last), "two final elements in a row")

  // block comes out of reset ready for items
  `WHT_ASSERT_IMPLY(a_ready_after_rst, clk, rst, $past(rst), !item_stall, "stalled after reset")

endmodule

bind walsh_hadamard_xor_transform_mod_p wht_checker u_wht_checker (.*);
